// ----- design/ufc_pkg.sv -----
// Shared types, constants and helpers for the UART frame collector.
`timescale 1ns / 1ps

package ufc_pkg;

    localparam int MAX_FRAME = 256;
    localparam int LEN_W     = 9;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 2;
    localparam int OUT_W     = 32;

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((MAX_FRAME < 256) ? MAX_FRAME : 256);
    localparam logic [LEN_W-1:0] DEFAULT_LEN_RST = 9'd256;

    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;

    typedef enum logic [IDX_W-1:0] {
        REG_PREFIX_EN = 2'd0,
        REG_DROP_LINE = 2'd1,
        REG_DEF_LEN   = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_BUSY  = 2'd1,
        ST_DONE  = 2'd2
    } rx_status_t;

    typedef struct packed {
        logic             prefix_en;
        logic             drop_line;
        logic [LEN_W-1:0] eff_len;
        logic             rearm;
        logic [LEN_W-1:0] rearm_len;
    } cfg_t;

    typedef struct packed {
        logic              byte_stored;
        logic [BYTE_W-1:0] store_index;
        logic [BYTE_W-1:0] store_value;
        logic              frame_done;
        logic [LEN_W-1:0]  frame_length;
        rx_status_t        rx_status;
    } result_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        begin
            if (v == '0)
                r = 9'd1;
            else if (v > LEN_CAP)
                r = LEN_CAP;
            else
                r = v;
            return r;
        end
    endfunction

    localparam logic [LEN_W-1:0] RESET_LEN = clamp_len(DEFAULT_LEN_RST);

endpackage

// ----- design/ufc_cfg_regs.sv -----
// Configuration registers of the frame collector.
`timescale 1ns / 1ps

module ufc_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ufc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ufc_pkg::LEN_W-1:0]  cfg_data,
    output ufc_pkg::cfg_t              cfg
);
    import ufc_pkg::*;

    logic             prefix_en_reg;
    logic             drop_line_reg;
    logic [LEN_W-1:0] eff_len_reg;
    logic [LEN_W-1:0] wr_len;

    assign wr_len = clamp_len(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_en_reg <= 1'b0;
            drop_line_reg <= 1'b0;
            eff_len_reg   <= RESET_LEN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PREFIX_EN: prefix_en_reg <= cfg_data[0];
                REG_DROP_LINE: drop_line_reg <= cfg_data[0];
                REG_DEF_LEN:   eff_len_reg   <= wr_len;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        cfg.prefix_en = prefix_en_reg;
        cfg.drop_line = drop_line_reg;
        cfg.eff_len   = eff_len_reg;
        // prefix mode or length writes restart the frame
        cfg.rearm     = cfg_we && (cfg_index == REG_PREFIX_EN || cfg_index == REG_DEF_LEN);
        cfg.rearm_len = (cfg_index == REG_DEF_LEN) ? wr_len : eff_len_reg;
    end

endmodule

// ----- design/ufc_frame_ctrl.sv -----
// Frame state and per-byte update of the frame collector.
`timescale 1ns / 1ps

module ufc_frame_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ufc_pkg::cfg_t               cfg,
    input  logic                        step,
    input  logic [ufc_pkg::BYTE_W-1:0]  rx_byte,
    output ufc_pkg::result_t            result
);
    import ufc_pkg::*;

    logic [LEN_W-1:0] target_reg, target_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic             prefix_taken_reg, prefix_taken_next;
    rx_status_t       status_reg, status_next;

    logic             line_char;
    logic [LEN_W-1:0] pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg       <= RESET_LEN;
            remain_reg       <= RESET_LEN;
            prefix_taken_reg <= 1'b0;
            status_reg       <= ST_READY;
        end
        else if (cfg.rearm)
        begin
            target_reg       <= cfg.rearm_len;
            remain_reg       <= cfg.rearm_len;
            prefix_taken_reg <= 1'b0;
        end
        else if (step)
        begin
            target_reg       <= target_next;
            remain_reg       <= remain_next;
            prefix_taken_reg <= prefix_taken_next;
            status_reg       <= status_next;
        end
    end

    assign line_char = (rx_byte == CHAR_NUL) || (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
    assign pos       = target_reg - remain_reg;

    always_comb
    begin
        target_next         = target_reg;
        remain_next         = remain_reg;
        prefix_taken_next   = prefix_taken_reg;
        status_next         = status_reg;
        result.byte_stored  = 1'b0;
        result.store_index  = '0;
        result.store_value  = '0;
        result.frame_done   = 1'b0;
        result.frame_length = '0;
        result.rx_status    = status_reg;

        if (cfg.prefix_en && !prefix_taken_reg)
        begin
            // zero length byte is skipped, next byte is read as length again
            if (rx_byte != '0)
            begin
                target_next       = clamp_len({1'b0, rx_byte});
                remain_next       = target_next;
                prefix_taken_next = 1'b1;
            end
        end
        else if (cfg.drop_line && line_char)
        begin
            // discarded
        end
        else
        begin
            if (line_char && (remain_reg != target_reg))
            begin
                // early end: length is what was stored so far
                target_next = pos;
                remain_next = '0;
            end
            else
            begin
                result.byte_stored = 1'b1;
                result.store_index = pos[BYTE_W-1:0];
                result.store_value = rx_byte;
                if (remain_reg != '0)
                    remain_next = remain_reg - 9'd1;
            end

            if (remain_next == '0)
            begin
                result.frame_done   = 1'b1;
                result.frame_length = target_next;
                result.rx_status    = ST_DONE;
                target_next         = cfg.eff_len;
                remain_next         = cfg.eff_len;
                prefix_taken_next   = 1'b0;
                status_next         = ST_BUSY;
            end
        end
    end

endmodule

// ----- design/uart_rx_frame_collector_unit.sv -----
// Top level of the UART frame collector: input and result registers around the frame logic.
`timescale 1ns / 1ps

// Channel   | Dir | Handshake          | Payload
// s_axis    | in  | s_axis_tvalid/ready| tdata[7:0] rx_byte
// m_axis    | out | m_axis_tvalid/ready| tdata 28 bits used, tlast = frame_done
// cfg       | in  | cfg_we             | cfg_index, cfg_data (9 bits)
//
// One item per cycle sustained while the output is not stalled; one result per item,
// passed through the input register, then the result register. The frame state
// updates when an item moves from the input register into the result register.
// Reset clears all control state; the frame arms with the default length 256.
// A stalled output holds its result and the input register still takes one item.

module uart_rx_frame_collector_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] byte_stored, [8:1] store_index, [16:9] store_value,
    // [25:17] frame_length, [27:26] rx_status, [31:28] zero
    output logic [ufc_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                        m_axis_tlast,  // frame_done
    input  logic                        cfg_we,
    input  logic [ufc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ufc_pkg::LEN_W-1:0]   cfg_data
);
    import ufc_pkg::*;

    cfg_t              cfg;
    result_t           result;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_last_reg;
    logic              advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    ufc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ufc_frame_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
        if (advance)
        begin
            out_data_reg <= {4'd0, result.rx_status, result.frame_length,
                             result.store_value, result.store_index, result.byte_stored};
            out_last_reg <= result.frame_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- tb/sv/uart_rx_frame_collector_unit_tb.sv -----
// Self-checking testbench for the UART frame collector: stream stimulus, predictor, scoreboard.
`timescale 1ns / 1ps

module uart_rx_frame_collector_unit_tb;

    import ufc_pkg::*;

    localparam logic [IDX_W-1:0] SPARE_REG = 2'd3;  // unmapped index, must be ignored
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;

    // Predicts one result per accepted byte and matches it against the block's output.
    class frame_scoreboard;
        bit               prefix_mode;
        bit               drop_mode;
        logic [LEN_W-1:0] default_len;
        logic [LEN_W-1:0] target_len;
        logic [LEN_W-1:0] left_len;
        bit               length_seen;
        rx_status_t       status_now;
        result_t          expected_q[$];
        int               mismatches;
        int               results_seen;
        int               frames_done;
        int               bytes_stored;

        function new();
            prefix_mode = 1'b0;
            drop_mode   = 1'b0;
            default_len = DEFAULT_LEN_RST;
            status_now  = ST_READY;
            restart_frame();
        endfunction

        function logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
            if (v == '0)
                return 9'd1;
            if (v > LEN_CAP)
                return LEN_CAP;
            return v;
        endfunction

        function void restart_frame();
            target_len  = sat_len(default_len);
            left_len    = target_len;
            length_seen = 1'b0;
        endfunction

        function void write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] v);
            case (idx)
                REG_PREFIX_EN:
                begin
                    prefix_mode = v[0];
                    restart_frame();
                end
                REG_DROP_LINE: drop_mode = v[0];
                REG_DEF_LEN:
                begin
                    default_len = v;
                    restart_frame();
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Returns 1 when the byte did something (length taken, stored or frame ended).
        function bit note_input(input logic [7:0] b);
            result_t r;
            bit      line_ch;
            bit      active;
            r       = '0;
            line_ch = (b == CHAR_NUL) || (b == CHAR_LF) || (b == CHAR_CR);
            active  = 1'b1;
            r.rx_status = status_now;
            if (prefix_mode && !length_seen)
            begin
                if (b != 8'h00)
                begin
                    target_len  = sat_len({1'b0, b});
                    left_len    = target_len;
                    length_seen = 1'b1;
                end
                else
                begin
                    active = 1'b0;
                end
            end
            else if (drop_mode && line_ch)
            begin
                active = 1'b0;
            end
            else
            begin
                // a line char after the first byte closes the frame short
                if (line_ch && left_len != target_len)
                begin
                    target_len = target_len - left_len;
                    left_len   = '0;
                end
                else
                begin
                    r.byte_stored = 1'b1;
                    r.store_index = 8'(target_len - left_len);
                    r.store_value = b;
                    bytes_stored++;
                    if (left_len != '0)
                        left_len--;
                end
                if (left_len == '0)
                begin
                    r.frame_done   = 1'b1;
                    r.frame_length = target_len;
                    r.rx_status    = ST_DONE;
                    frames_done++;
                    restart_frame();
                    status_now = ST_BUSY;
                end
            end
            expected_q.push_back(r);
            return active;
        endfunction

        function void check_result(input logic [OUT_W-1:0] data, input logic last);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h (last=%b) with no item pending", data, last);
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            if (data[0] !== want.byte_stored || data[8:1] !== want.store_index ||
                data[16:9] !== want.store_value || last !== want.frame_done ||
                data[25:17] !== want.frame_length || data[27:26] !== want.rx_status ||
                data[31:28] !== 4'h0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: want st=%0d idx=%0d val=%02h done=%0d len=%0d sts=%0d",
                             results_seen, want.byte_stored, want.store_index,
                             want.store_value, want.frame_done, want.frame_length,
                             want.rx_status);
                if (mismatches <= 10)
                    $display("result %0d: got st=%0d idx=%0d val=%02h done=%0d len=%0d sts=%0d",
                             results_seen, data[0], data[8:1], data[16:9], last,
                             data[25:17], data[27:26]);
                if (mismatches <= 10)
                    $display("result %0d: got pad=%h", results_seen, data[31:28]);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b1;
    // [0] byte_stored, [8:1] store_index, [16:9] store_value,
    // [25:17] frame_length, [27:26] rx_status, [31:28] zero
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tlast;           // frame_done
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [LEN_W-1:0]   cfg_data = '0;

    frame_scoreboard    sb = new();
    bit                 calm = 1'b0;
    bit                 stall_request = 1'b0;
    int                 items_sent = 0;
    int                 useful_items = 0;
    int                 settings_used = 0;
    int                 idle_cycles = 0;

    uart_rx_frame_collector_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] noisy_byte(input int line_pct);
        if ($urandom_range(0, 99) < line_pct)
        begin
            case ($urandom_range(0, 2))
                0: return CHAR_NUL;
                1: return CHAR_LF;
                default: return CHAR_CR;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (sb.note_input(b))
            useful_items++;
    endtask

    // Let every outstanding result come back, plus a little margin for the pipeline.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input bit p, input bit d, input logic [LEN_W-1:0] len,
                             input bit drop_only);
        logic [IDX_W-1:0] idx_list[$];
        logic [LEN_W-1:0] val_list[$];
        drain();
        idx_list.push_back(REG_DROP_LINE);
        val_list.push_back({8'($urandom), d});
        if (!drop_only)
        begin
            idx_list.push_back(SPARE_REG);
            val_list.push_back(9'($urandom));
            idx_list.push_back(REG_PREFIX_EN);
            val_list.push_back({8'($urandom), p});
            idx_list.push_back(REG_DEF_LEN);
            val_list.push_back(len);
        end
        foreach (idx_list[i])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            @(posedge clk);
            sb.write_reg(idx_list[i], val_list[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic run_random(input bit p, input bit d, input logic [LEN_W-1:0] len,
                              input int goal, input bit squeeze);
        int          start;
        int          body;
        int          pick;
        logic [7:0]  len_byte;
        configure(p, d, len, 1'b0);
        start = useful_items;
        if (squeeze)
            stall_request = 1'b1;
        while (useful_items - start < goal)
        begin
            if (!p)
            begin
                push_byte(noisy_byte(d ? 5 : 8));
            end
            else
            begin
                // mostly well-formed length-prefixed frames with random content
                pick = $urandom_range(0, 19);
                case (pick)
                    0: len_byte = 8'h00;
                    1: len_byte = CHAR_LF;
                    2: len_byte = CHAR_CR;
                    3: len_byte = 8'($urandom_range(17, 255));
                    default: len_byte = 8'($urandom_range(1, 12));
                endcase
                push_byte(len_byte);
                if (len_byte != 8'h00)
                begin
                    body = (len_byte > 16) ? $urandom_range(1, 16) : len_byte;
                    repeat (body)
                        push_byte(noisy_byte(8));
                    // long frame cut short on purpose
                    if (len_byte > 16 && !d)
                        push_byte(CHAR_LF);
                end
            end
        end
    endtask

    initial
    begin : sequencer
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: default length 256, line chars end frames
        push_byte(CHAR_NUL);    // first byte, kept
        push_byte(CHAR_LF);     // closes a one-byte frame
        push_byte(CHAR_CR);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(8'h01);
        push_byte(CHAR_LF);

        configure(1'b1, 1'b0, 9'd4, 1'b0);
        push_byte(8'h00);       // zero length byte, skipped
        push_byte(8'h03);
        push_byte(CHAR_LF);     // first byte of frame: stored
        push_byte(8'h41);
        push_byte(CHAR_CR);     // early end
        push_byte(8'h02);
        push_byte(8'hFE);
        push_byte(8'h10);
        push_byte(8'h05);
        push_byte(8'h11);
        push_byte(8'h22);

        // switching drop mode mid-frame must not restart it
        configure(1'b1, 1'b1, 9'd4, 1'b1);
        push_byte(CHAR_LF);
        push_byte(8'h33);
        push_byte(8'h44);
        push_byte(8'h55);

        configure(1'b0, 1'b1, 9'd0, 1'b0);
        push_byte(CHAR_NUL);
        push_byte(CHAR_CR);
        push_byte(8'h5A);

        run_random(1'b1, 1'b0, 9'd5,   70,  1'b0);
        run_random(1'b0, 1'b0, 9'd3,   60,  1'b1);
        run_random(1'b1, 1'b1, 9'd0,   50,  1'b0);
        run_random(1'b0, 1'b1, 9'd511, 262, 1'b1);   // one full 256-byte frame
        run_random(1'b0, 1'b0, 9'd1,   30,  1'b0);
        calm = 1'b1;
        run_random(1'b1, 1'b0, 9'd256, 50,  1'b0);

        drain();
        repeat (10) @(posedge clk);
        $display("sent %0d bytes (%0d effective) across %0d register settings",
                 items_sent, useful_items, settings_used + 1);
        $display("checked %0d results: %0d frames closed, %0d bytes stored, %0d mismatches",
                 sb.results_seen, sb.frames_done, sb.bytes_stored, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("uart_rx_frame_collector_unit regression: pass");
        else
            $display("uart_rx_frame_collector_unit regression: fail");
        $finish;
    end

    initial
    begin : sink
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                // long hold so the input side backs up
                stall_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("uart_rx_frame_collector_unit regression: fail");
            $finish;
        end
    end

endmodule
